>>> src/dwg_pkg.sv
// ----------------------------------------------------------------------------
// dwg_pkg
// shared widths, register indexes, waveform codes and constants for the
// dac waveform sample generator
// ----------------------------------------------------------------------------
`default_nettype none

package dwg_pkg;

  localparam int CODE_W    = 12;
  localparam int SINE_W    = 15;
  localparam int IDX_W     = 7;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  typedef logic [SINE_W-1:0] sine_t;
  typedef logic [CODE_W-1:0] code_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FRACTION = 2'd3;

  // waveform codes
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd2;

  // reset values
  localparam logic [1:0]  RST_WAVE_SHAPE    = SHAPE_SINE;
  localparam logic [10:0] RST_AMPLITUDE     = 11'd2047;
  localparam logic [15:0] RST_PHASE_OFFSET  = 16'd0;
  localparam logic [16:0] RST_DUTY_FRACTION = 17'd45875;

  localparam int          DAC_TOP     = 4095;
  localparam logic [11:0] MID_LO      = 12'd2047;
  localparam logic [16:0] DUTY_FULL   = 17'd65536;
  localparam logic [27:0] SINE_BASE   = 28'd134184960;  // 4095 * 32768
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

`default_nettype wire

>>> src/dwg_sine_rom.sv
// ----------------------------------------------------------------------------
// dwg_sine_rom
// quarter-wave sine table in unsigned q0.15, built at elaboration, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module dwg_sine_rom
  import dwg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire                                      clk,
  input  wire                                      rd_en,
  input  wire  [$clog2(SINE_TABLE_DEPTH+1)-1:0]    rd_addr,
  output sine_t                                    rd_data
);

  typedef logic [SINE_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // nested taylor form in unsigned q2.30, every step truncated
  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] f;
    logic [63:0] s;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      f  = ONE_Q30;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd272;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd210;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd156;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd110;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd72;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd42;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd20;
      f  = ONE_Q30 - ((x2 * f) >> 30) / 64'd6;
      s  = (x * f) >> 30;
      s  = (s + 64'd16384) >> 15;
      tab[k] = (s > 64'd32767) ? 15'd32767 : s[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  sine_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/dac_waveform_sample_generator.sv
// an accepted request passes through 6 stages and then the output register to reach out_valid
// throughput: one request per cycle unless in_stall holds it off; the seven stages hold up to seven requests in flight
// the sine rom read in stage 6 and the constant-divider multiplies set the stage split
// reset (rst_n low, synchronous): all valid bits clear, configuration registers take their reset values
// stall is handled stage by stage, so bubbles collapse while the output waits
// ----------------------------------------------------------------------------
// dac_waveform_sample_generator
// maps a sample position within one period to a 12-bit dac code for a sine,
// triangle or square wave, with amplitude, phase offset and duty control
// ----------------------------------------------------------------------------
`default_nettype none

module dac_waveform_sample_generator
  import dwg_pkg::*;
#(
  parameter int PERIOD_SAMPLES   = 100,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // configuration
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_W-1:0]     cfg_wdata,
  // request channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [IDX_W-1:0]     in_sample_index,
  // result channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [CODE_W-1:0]    out_dac_code
);

  // --------------------------------------------------------------------------
  // derived sizes
  // --------------------------------------------------------------------------
  localparam int P     = PERIOD_SAMPLES;
  localparam int D     = SINE_TABLE_DEPTH;
  localparam int FULL  = 4 * D;                 // table steps per period
  localparam int TW    = $clog2(FULL);          // phase step t
  localparam int AW    = $clog2(D + 1);         // rom address 0..D
  localparam int BW    = $clog2(P);             // position within period
  localparam int PW    = $clog2(P + 1);         // values up to P
  localparam int VW    = $clog2(FULL * P);      // FULL * position
  localparam int RW    = VW + 1;
  localparam int SHP   = VW + BW;
  // exact divide by P for values below 2**VW: multiply by ceil(2**SHP / P)
  localparam logic [63:0] RECIP_P = ((64'd1 << SHP) + 64'(P) - 64'd1) / PERIOD_SAMPLES;

  // triangle
  localparam int H     = P / 2;
  localparam int DIV2H = 2 * H;
  localparam int NW    = BW + 1;                // signed level numerator
  localparam int UW    = BW + 13;               // unsigned triangle total
  localparam int TOTW  = UW + 1;
  localparam int MIDH  = DAC_TOP * H;
  localparam int L2    = $clog2(DIV2H);
  localparam int SH2   = UW + L2;
  localparam int R2W   = UW + 1;
  localparam logic [63:0] RECIP_2H = ((64'd1 << SH2) + 64'(DIV2H) - 64'd1) / DIV2H;
  localparam int TQW   = CODE_W + 1;

  localparam int NSTG  = 6;

  // sample index wraps modulo the period
  typedef logic [BW-1:0] idxmod_t [0:(2**IDX_W)-1];

  function automatic idxmod_t build_idxmod();
    idxmod_t tab;
    for (int k = 0; k < 2**IDX_W; k++) begin
      tab[k] = BW'(k % PERIOD_SAMPLES);
    end
    return tab;
  endfunction

  localparam idxmod_t IDX_MOD = build_idxmod();

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  wave_shape_r;
  logic [10:0] amplitude_r;
  logic [15:0] phase_offset_r;
  logic [16:0] duty_fraction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r    <= RST_WAVE_SHAPE;
      amplitude_r     <= RST_AMPLITUDE;
      phase_offset_r  <= RST_PHASE_OFFSET;
      duty_fraction_r <= RST_DUTY_FRACTION;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAVE_SHAPE:    wave_shape_r    <= cfg_wdata[1:0];
        CFG_AMPLITUDE:     amplitude_r     <= cfg_wdata[10:0];
        CFG_PHASE_OFFSET:  phase_offset_r  <= cfg_wdata[15:0];
        CFG_DUTY_FRACTION: duty_fraction_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !out_valid_r || !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
      if (rdy[NSTG]) begin
        out_valid_r <= vld_r[NSTG-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: wrap the index, split the phase offset
  //   sine phase in table steps = FULL*b/P + FULL*ph/65536
  //   second term: integer part i2 and 16-bit fraction f2
  // --------------------------------------------------------------------------
  logic [15+TW:0]  s1_ph4;
  logic [15+PW:0]  s1_php;
  logic [BW-1:0]   s1_b_nxt,     s1_b_r;
  logic [TW-1:0]   s1_i2_nxt,    s1_i2_r;
  logic [15:0]     s1_f2_nxt,    s1_f2_r;
  logic [BW-1:0]   s1_start_nxt, s1_start_r;

  always_comb begin
    s1_b_nxt     = IDX_MOD[in_sample_index];
    s1_ph4       = (16+TW)'(phase_offset_r) * (16+TW)'(FULL);
    s1_i2_nxt    = s1_ph4[16 +: TW];
    s1_f2_nxt    = s1_ph4[15:0];
    // triangle rotation in whole samples
    s1_php       = (16+PW)'(phase_offset_r) * (16+PW)'(P);
    s1_start_nxt = s1_php[16 +: BW];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_b_r     <= s1_b_nxt;
      s1_i2_r    <= s1_i2_nxt;
      s1_f2_r    <= s1_f2_nxt;
      s1_start_r <= s1_start_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: i1 = floor(FULL*b / P) by reciprocal, triangle position,
  //          square high/low decision
  // --------------------------------------------------------------------------
  logic [VW-1:0]     s2_v_nxt,   s2_v_r;
  logic [VW+RW-1:0]  s2_prod;
  logic [TW-1:0]     s2_i1_nxt,  s2_i1_r;
  logic [BW:0]       s2_sum;
  logic [BW-1:0]     s2_pos_nxt, s2_pos_r;
  logic [16:0]       s2_duty;
  logic [PW+16:0]    s2_hp;
  logic [PW-1:0]     s2_high;
  logic              s2_sq_nxt,  s2_sq_r;
  logic [TW-1:0]     s2_i2_r;
  logic [15:0]       s2_f2_r;

  always_comb begin
    s2_v_nxt   = VW'(s1_b_r) * VW'(FULL);
    s2_prod    = (VW+RW)'(s2_v_nxt) * (VW+RW)'(RECIP_P[RW-1:0]);
    s2_i1_nxt  = s2_prod[SHP +: TW];
    s2_sum     = (BW+1)'(s1_b_r) + (BW+1)'(s1_start_r);
    s2_pos_nxt = (s2_sum >= (BW+1)'(P)) ? BW'(s2_sum - (BW+1)'(P)) : s2_sum[BW-1:0];
    // duty above one saturates
    s2_duty    = (duty_fraction_r > DUTY_FULL) ? DUTY_FULL : duty_fraction_r;
    s2_hp      = (PW+17)'(P) * (PW+17)'(s2_duty);
    s2_high    = s2_hp[16 +: PW];
    s2_sq_nxt  = PW'(s1_b_r) < s2_high;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_v_r   <= s2_v_nxt;
      s2_i1_r  <= s2_i1_nxt;
      s2_pos_r <= s2_pos_nxt;
      s2_sq_r  <= s2_sq_nxt;
      s2_i2_r  <= s1_i2_r;
      s2_f2_r  <= s1_f2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: remainder r1 of FULL*b / P, f2*P for the carry test,
  //          triangle numerator
  // --------------------------------------------------------------------------
  logic [VW-1:0]          s3_diff;
  logic [BW-1:0]          s3_r1_nxt,  s3_r1_r;
  logic [15+PW:0]         s3_f2p_nxt, s3_f2p_r;
  logic signed [BW+2:0]   s3_pos_w;
  logic signed [BW+2:0]   s3_num_w;
  logic signed [NW-1:0]   s3_num_nxt, s3_num_r;
  logic [TW-1:0]          s3_i1_r;
  logic [TW-1:0]          s3_i2_r;
  logic                   s3_sq_r;

  always_comb begin
    s3_diff    = s2_v_r - VW'(s2_i1_r) * VW'(P);
    s3_r1_nxt  = s3_diff[BW-1:0];
    s3_f2p_nxt = (16+PW)'(s2_f2_r) * (16+PW)'(P);
    s3_pos_w   = signed'((BW+3)'(s2_pos_r)) <<< 1;
    if (s2_pos_r < BW'(H)) begin
      s3_num_w = s3_pos_w - signed'((BW+3)'(H));
    end else begin
      s3_num_w = signed'((BW+3)'(3 * H)) - s3_pos_w;
    end
    s3_num_nxt = s3_num_w[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_r1_r  <= s3_r1_nxt;
      s3_f2p_r <= s3_f2p_nxt;
      s3_num_r <= s3_num_nxt;
      s3_i1_r  <= s2_i1_r;
      s3_i2_r  <= s2_i2_r;
      s3_sq_r  <= s2_sq_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: phase step t = i1 + i2 + carry, wrapped to one period;
  //          triangle total 4095*h + 2*amplitude*num
  // --------------------------------------------------------------------------
  logic                   s4_carry;
  logic [TW:0]            s4_tsum;
  logic [TW-1:0]          s4_t_nxt, s4_t_r;
  logic signed [11:0]     s4_amp_s;
  logic signed [TOTW-1:0] s4_ampnum;
  logic signed [TOTW-1:0] s4_total;
  logic [UW-1:0]          s4_tot_nxt, s4_tot_r;
  logic                   s4_sq_r;

  always_comb begin
    // fractions r1/P + f2/65536 reach one
    s4_carry   = s3_f2p_r >= {PW'(P) - PW'(s3_r1_r), 16'h0000};
    s4_tsum    = (TW+1)'(s3_i1_r) + (TW+1)'(s3_i2_r) + (TW+1)'(s4_carry);
    s4_t_nxt   = (s4_tsum >= (TW+1)'(FULL)) ? TW'(s4_tsum - (TW+1)'(FULL))
                                             : s4_tsum[TW-1:0];
    s4_amp_s   = signed'({1'b0, amplitude_r});
    s4_ampnum  = TOTW'(s4_amp_s * s3_num_r);
    s4_total   = TOTW'(MIDH) + (s4_ampnum <<< 1);
    s4_tot_nxt = s4_total[TOTW-1] ? '0 : s4_total[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_t_r   <= s4_t_nxt;
      s4_tot_r <= s4_tot_nxt;
      s4_sq_r  <= s3_sq_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: quadrant and mirrored rom address; triangle total / 2h
  // --------------------------------------------------------------------------
  logic [1:0]          s5_q_nxt,    s5_q_r;
  logic [AW-1:0]       s5_rem;
  logic [AW-1:0]       s5_addr_nxt, s5_addr_r;
  logic [UW+R2W-1:0]   s5_prod;
  logic [TQW-1:0]      s5_tq_nxt,   s5_tq_r;
  logic                s5_sq_r;

  always_comb begin
    if (s4_t_r >= TW'(3 * D)) begin
      s5_q_nxt = 2'd3;
      s5_rem   = AW'(s4_t_r - TW'(3 * D));
    end else if (s4_t_r >= TW'(2 * D)) begin
      s5_q_nxt = 2'd2;
      s5_rem   = AW'(s4_t_r - TW'(2 * D));
    end else if (s4_t_r >= TW'(D)) begin
      s5_q_nxt = 2'd1;
      s5_rem   = AW'(s4_t_r - TW'(D));
    end else begin
      s5_q_nxt = 2'd0;
      s5_rem   = AW'(s4_t_r);
    end
    // odd quadrants run the table backwards
    s5_addr_nxt = s5_q_nxt[0] ? AW'(D) - s5_rem : s5_rem;
    s5_prod     = (UW+R2W)'(s4_tot_r) * (UW+R2W)'(RECIP_2H[R2W-1:0]);
    s5_tq_nxt   = s5_prod[SH2 +: TQW];
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_q_r    <= s5_q_nxt;
      s5_addr_r <= s5_addr_nxt;
      s5_tq_r   <= s5_tq_nxt;
      s5_sq_r   <= s4_sq_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: sine table read
  // --------------------------------------------------------------------------
  sine_t           s6_mag;
  logic [1:0]      s6_q_r;
  logic [TQW-1:0]  s6_tq_r;
  logic            s6_sq_r;

  dwg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (rdy[5]),
    .rd_addr (s5_addr_r),
    .rd_data (s6_mag)
  );

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_q_r  <= s5_q_r;
      s6_tq_r <= s5_tq_r;
      s6_sq_r <= s5_sq_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: scale about mid-code and pick the shape
  // --------------------------------------------------------------------------
  logic [27:0]     s7_dev;
  logic [27:0]     s7_snum;
  logic [CODE_W:0] s7_hi;
  code_t           code_nxt;
  code_t           out_code_r;

  always_comb begin
    s7_dev  = (28'(amplitude_r) * 28'(s6_mag)) << 1;
    // second half of the period is negative
    s7_snum = s6_q_r[1] ? SINE_BASE - s7_dev : SINE_BASE + s7_dev;
    s7_hi   = (CODE_W+1)'(MID_LO) + (CODE_W+1)'(amplitude_r);
    case (wave_shape_r)
      SHAPE_SINE: begin
        code_nxt = s7_snum[16 +: CODE_W];
      end
      SHAPE_TRIANGLE: begin
        code_nxt = (s6_tq_r > TQW'(DAC_TOP)) ? CODE_W'(DAC_TOP) : s6_tq_r[CODE_W-1:0];
      end
      SHAPE_SQUARE: begin
        if (s6_sq_r) begin
          code_nxt = (s7_hi > (CODE_W+1)'(DAC_TOP)) ? CODE_W'(DAC_TOP)
                                                    : s7_hi[CODE_W-1:0];
        end else begin
          code_nxt = MID_LO - CODE_W'(amplitude_r);
        end
      end
      default: begin
        code_nxt = MID_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_code_r <= code_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_code = out_code_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the input is held off only when every stage is full and the output waits
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_valid_r && out_stall))
    else $error("in_stall raised while the pipeline has room");

  // mirrored address never leaves the quarter table
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (s5_addr_r <= AW'(D)))
    else $error("sine rom address beyond table depth");

  // triangle quotient never exceeds 4094, one below the peak code
  a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (s5_tq_r <= TQW'(4094)))
    else $error("triangle quotient out of range");

endmodule

`default_nettype wire
